[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the conversion unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALL(lbl, clk, prop, msg)
`endif
`endif

[rtl/fic_pkg.sv]
// Package of types and constants for the float/int conversion unit.
package fic_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DATA_W);

  // Operation codes of req_type; the fourth code is unused and gives zero.
  typedef enum logic [1:0] {
    OP_I2F   = 2'd0,
    OP_F2I   = 2'd1,
    OP_FLOOR = 2'd2
  } op_t;

  localparam logic [DATA_W-1:0] INT_MAX_W   = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] INT_MIN_W   = 32'h8000_0000;
  localparam logic [DATA_W-1:0] I2F_MIN_RES = 32'hCF00_0000;
  localparam logic [DATA_W-1:0] NEG_ONE_F   = 32'hBF80_0000;
  localparam logic [DATA_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;

  localparam logic [7:0] EXP_BIAS      = 8'd127;
  localparam logic [7:0] EXP_I2F_TOP   = 8'd158;
  localparam logic [7:0] EXP_F2I_SAT   = 8'd158;
  localparam logic [7:0] EXP_F2I_TOP   = 8'd157;
  localparam logic [7:0] EXP_F2I_ZERO  = 8'd126;
  localparam logic [7:0] EXP_FLOOR_INT = 8'd150;

  // Stage 2 word: operand decoded, shift amount known, fixed results settled.
  typedef struct packed {
    op_t               op;
    logic              sign;
    logic [DATA_W-1:0] src;
    logic [CNT_W-1:0]  sa;
    logic              fixed;
    logic [DATA_W-1:0] fixval;
  } s2_t;

  // Stage 3 word: the final add operands, or a fixed result.
  typedef struct packed {
    op_t               op;
    logic              fixed;
    logic [DATA_W-1:0] fixval;
    logic [DATA_W-1:0] add_a;
    logic [DATA_W-1:0] add_b;
  } s3_t;

endpackage

[rtl/float_int_conversion_unit_top.sv]
// Top level of the single-precision float/int conversion pipeline.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   request | in_valid, in_ready, req_type,    | in
//           | operand                          |
//   result  | out_valid, out_ready, result     | out
//
// Four register stages: negate, leading-zero count and decode, shift,
// final add. An accepted word passes the stage 1, 2 and 3 registers before
// out_valid rises with its result; one word can enter every cycle unless out_ready stalls.
// Each stage holds its word while the stage ahead is full and stalled, so
// bubbles are squeezed out and a stall loses nothing. Synchronous reset
// clears the stage valid bits only.
`include "assert_macros.svh"

module float_int_conversion_unit_top
  import fic_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [DATA_W-1:0] operand,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] result
);

  // Stage registers and valid bits.
  logic              v1, v2, v3;
  op_t               op1;
  logic [DATA_W-1:0] a1, mag1;
  s2_t               s2, s2_next;
  s3_t               s3, s3_next;
  logic              en1, en2, en3, en4;

  // A stage may load when it is empty or the stage ahead loads too.
  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  // Stage 1: capture the word and the integer magnitude.
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      op1  <= op_t'(req_type);
      a1   <= operand;
      mag1 <= operand[DATA_W-1] ? (~operand + 1'b1) : operand;
    end
  end

  // Stage 2: leading-zero count, shift amounts and the fixed-result cases.
  logic [CNT_W-1:0] lz;
  logic [7:0]       e1;
  logic             sign1;

  fic_lzc u_lzc (
    .value (mag1),
    .count (lz)
  );

  assign e1    = a1[30:23];
  assign sign1 = a1[DATA_W-1];

  always_comb begin
    logic [7:0] diff;
    diff            = 8'd0;
    s2_next.op      = op1;
    s2_next.sign    = sign1;
    s2_next.src     = a1;
    s2_next.sa      = '0;
    s2_next.fixed   = 1'b1;
    s2_next.fixval  = '0;
    unique case (op1)
      OP_I2F: begin
        // Zero and the most negative integer have fixed encodings.
        s2_next.src    = mag1;
        s2_next.sa     = lz;
        s2_next.fixed  = (a1 == '0) || (a1 == INT_MIN_W);
        s2_next.fixval = (a1 == INT_MIN_W) ? I2F_MIN_RES : '0;
      end
      OP_F2I: begin
        // Saturate large values, flush tiny ones; otherwise shift right.
        diff           = EXP_F2I_TOP - e1;
        s2_next.sa     = diff[CNT_W-1:0];
        s2_next.fixed  = (e1 >= EXP_F2I_SAT) || (e1 < EXP_F2I_ZERO);
        if (e1 >= EXP_F2I_SAT) begin
          s2_next.fixval = sign1 ? INT_MIN_W : INT_MAX_W;
        end
      end
      OP_FLOOR: begin
        // Integral values pass; magnitudes below one go to 0 or -1.0.
        diff           = EXP_FLOOR_INT - e1;
        s2_next.sa     = diff[CNT_W-1:0];
        s2_next.fixed  = (e1 >= EXP_FLOOR_INT) || (e1 < EXP_BIAS);
        if (e1 >= EXP_FLOOR_INT) begin
          s2_next.fixval = a1;
        end else if (sign1) begin
          s2_next.fixval = NEG_ONE_F;
        end
      end
      default: begin
        s2_next.fixed  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      s2 <= s2_next;
    end
  end

  // Stage 3: shift and form the two operands of the final add.
  always_comb begin
    logic [DATA_W-1:0] norm, y, z, mask;
    logic [7:0]        ex;
    norm           = s2.src << s2.sa;
    ex             = EXP_I2F_TOP - {3'b000, s2.sa};
    y              = {1'b1, s2.src[22:0], 8'h00};
    z              = y >> s2.sa;
    mask           = ~(ALL_ONES << s2.sa);
    s3_next.op     = s2.op;
    s3_next.fixed  = s2.fixed;
    s3_next.fixval = s2.fixval;
    s3_next.add_a  = '0;
    s3_next.add_b  = '0;
    unique case (s2.op)
      OP_I2F: begin
        // Round half away from zero: the first dropped bit is added to the magnitude.
        s3_next.add_a = {s2.sign, ex, norm[30:8]};
        s3_next.add_b = {31'd0, norm[7]};
      end
      OP_F2I: begin
        // Round and negate in one add: -(a + b) is ~a + !b.
        s3_next.add_a = {1'b0, z[DATA_W-1:1]} ^ {DATA_W{s2.sign}};
        s3_next.add_b = {31'd0, z[0] ^ s2.sign};
      end
      OP_FLOOR: begin
        // Clear the fraction; a negative with a fraction steps one unit down.
        s3_next.add_a = s2.src & ~mask;
        s3_next.add_b = (s2.sign && ((s2.src & mask) != '0)) ?
                        (32'd1 << s2.sa) : '0;
      end
      default: begin
        s3_next.add_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      s3 <= s3_next;
    end
  end

  // Stage 4: final add into the output register.
  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      result <= s3.fixed ? s3.fixval : (s3.add_a + s3.add_b);
    end
  end

  // Checks on the pipeline control and the datapath.
  `ASSERT_ALL(a_reset_clears, clk, rst |=> !v1 && !v2 && !v3 && !out_valid, "valid after reset")
  `ASSERT_RST(a_full_when_blocked, clk, rst, !in_ready |-> v1 && v2 && v3 && out_valid, "ready low with a bubble")
  `ASSERT_RST(a_s2_hold, clk, rst, v2 && !en3 |=> v2 && $stable(s2), "stage 2 word changed in a stall")
  `ASSERT_RST(a_i2f_exp, clk, rst, v3 && !s3.fixed && s3.op == OP_I2F |-> s3.add_a[30:23] >= EXP_BIAS && s3.add_a[30:23] < EXP_I2F_TOP, "int to float exponent out of range")

endmodule

[rtl/fic_lzc.sv]
// Leading zero counter for a nonzero data word.
module fic_lzc
  import fic_pkg::*;
(
  input  logic [DATA_W-1:0] value,
  output logic [CNT_W-1:0]  count
);

  // The highest set bit wins, so scan upward and let later hits override.
  always_comb begin
    count = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (value[i]) begin
        count = CNT_W'(DATA_W - 1 - i);
      end
    end
  end

endmodule
